/* design/limit_order_book_matcher_top_defines.svh */
// Assertion macros used by the matcher top design file.
`ifndef LIMIT_ORDER_BOOK_MATCHER_TOP_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define LOB_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define LOB_ASSERT_RST(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define LOB_ASSERT(label, clk, rst_n, prop)
`define LOB_ASSERT_RST(label, clk, prop)
`endif
`endif

/* design/lobm_pkg.sv */
package lobm_pkg;
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_MATCH,
		ST_POP,
		ST_SCAN,
		ST_SHIFT,
		ST_PUT,
		ST_SUM
	} lobm_state_t;

	localparam logic RK_TRADE = 1'b0;
	localparam logic RK_SUMMARY = 1'b1;

	localparam logic [1:0] IS_NEW = 2'd0;
	localparam logic [1:0] IS_PARTIAL = 2'd1;
	localparam logic [1:0] IS_FILLED = 2'd2;

	localparam logic SIDE_BUY = 1'b0;
	localparam logic SIDE_SELL = 1'b1;
endpackage

/* design/lobm_mem.sv */
module lobm_mem import lobm_pkg::*; #(
	parameter int AW = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [75:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [75:0]   rdata
);
	logic [75:0] mem [0:(1<<AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* design/limit_order_book_matcher_top.sv */
// Flow: a zero quantity order goes straight to its summary item. Otherwise each trade is
// emitted in turn, a filled resting entry is removed by moving its book's later entries up,
// a head that does not cross ends matching, and the rest is inserted, shifting those behind.
// Throughput: one order at a time; in_stall stays high until the summary item is loaded,
// and the next order is taken in the cycle after at the earliest. Output stalls delay it.
// Reset: arst_n clears all book counts (every book empty), the sequencer and out_valid.
`include "limit_order_book_matcher_top_defines.svh"
module limit_order_book_matcher_top import lobm_pkg::*; #(
	parameter int BOOK_DEPTH = 16,
	parameter int ZONE_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        side,
	input  logic [1:0]  zone,
	input  logic [31:0] order_id,
	input  logic [19:0] limit_price,
	input  logic [23:0] order_quantity,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [31:0] resting_id,
	output logic [31:0] incoming_id,
	output logic [23:0] trade_quantity,
	output logic [19:0] trade_price,
	output logic [23:0] resting_left,
	output logic        resting_status,
	output logic [23:0] incoming_left,
	output logic [1:0]  incoming_status,
	output logic        rested,
	output logic        book_full,
	output logic        last
);
	localparam int BOOKS = ZONE_COUNT * 2;
	localparam int DW = $clog2(BOOK_DEPTH);
	localparam int CW = $clog2(BOOK_DEPTH + 1);
	localparam int BW = $clog2(BOOKS);
	localparam int AW = BW + DW;

	lobm_state_t state_q, state_d;
	logic [CW-1:0] count_q [0:BOOKS-1];
	logic          sell_q;
	logic [BW-1:0] own_q, opp_q;
	logic [31:0]   id_q;
	logic [19:0]   limit_q;
	logic [23:0]   qty_q, rem_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] trades_q;
	logic          wait_q;
	logic          ovalid_q;
	logic          full_q;
	logic          out_load;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [75:0]   wdata, rdata;
	logic [19:0]   rp;
	logic [23:0]   rq;
	logic [31:0]   rid;
	logic [23:0]   tq;
	logic [CW-1:0] opp_n, own_n;
	logic          is_cross, behind;
	logic [BW-1:0] zsel;
	logic [1:0]    zmod;

	assign rp = rdata[75:56];
	assign rq = rdata[55:32];
	assign rid = rdata[31:0];
	assign tq = (rem_q < rq) ? rem_q : rq;
	assign opp_n = count_q[opp_q];
	assign own_n = count_q[own_q];
	assign is_cross = sell_q ? (rp >= limit_q) : (rp <= limit_q);
	assign behind = sell_q ? (rp <= limit_q) : (rp >= limit_q);
	assign zsel = BW'({zmod, 1'b0});

	always_comb begin
		case (zone)
			2'd0: zmod = 2'd0;
			2'd1: zmod = 2'(1 % ZONE_COUNT);
			2'd2: zmod = 2'(2 % ZONE_COUNT);
			2'd3: zmod = 2'(3 % ZONE_COUNT);
			default: zmod = 2'd0;
		endcase
	end

	lobm_mem #(.AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	function automatic logic [AW-1:0] addr(input logic [BW-1:0] b, input logic [CW-1:0] i);
		return AW'(AW'(b) * AW'(BOOK_DEPTH) + AW'(i));
	endfunction

	logic [CW-1:0] scan_pos_q, shift_i_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_HEAD;
			ST_HEAD: begin
				if (rem_q == '0 || opp_n == '0 || trades_q == CW'(BOOK_DEPTH)) begin
					state_d = (rem_q == '0) ? ST_SUM : ST_SCAN;
				end else begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				if (!wait_q && !(out_valid && out_stall)) begin
					if (!is_cross) state_d = ST_SCAN;
					else if (tq == rq) state_d = ST_POP;
					else state_d = ST_HEAD;
				end
			end
			ST_POP: if (!wait_q && pos_q + 1'b1 >= opp_n) state_d = ST_HEAD;
			ST_SCAN: begin
				if (own_n == CW'(BOOK_DEPTH)) state_d = ST_SUM;
				else if (!wait_q && (pos_q == own_n || !behind)) state_d = ST_SHIFT;
			end
			ST_SHIFT: if (shift_i_q == scan_pos_q) state_d = ST_PUT;
			ST_PUT: state_d = ST_SUM;
			ST_SUM: if (!(out_valid && out_stall)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		out_load = 1'b0;
		waddr = addr(opp_q, '0);
		wdata = {limit_q, rem_q, id_q};
		raddr = addr(opp_q, '0);
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_HEAD: raddr = addr(opp_q, '0);
			ST_MATCH: begin
				raddr = addr(opp_q, '0);
				if (!wait_q && !(out_valid && out_stall) && is_cross) begin
					out_load = 1'b1;
					if (tq != rq) begin
						we = 1'b1;
						wdata = {rp, 24'(rq - tq), rid};
					end
				end
			end
			ST_POP: begin
				raddr = addr(opp_q, pos_q + 1'b1);
				if (!wait_q) begin
					we = 1'b1;
					waddr = addr(opp_q, pos_q);
					wdata = rdata;
				end
			end
			ST_SCAN: raddr = addr(own_q, pos_q);
			ST_SHIFT: begin
				raddr = addr(own_q, shift_i_q - 1'b1);
				if (!wait_q && shift_i_q != scan_pos_q) begin
					we = 1'b1;
					waddr = addr(own_q, shift_i_q);
					wdata = rdata;
				end
			end
			ST_PUT: begin
				we = 1'b1;
				waddr = addr(own_q, scan_pos_q);
			end
			ST_SUM: out_load = !(out_valid && out_stall);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int b = 0; b < BOOKS; b++) count_q[b] <= '0;
			wait_q <= 1'b0;
			ovalid_q <= 1'b0;
			full_q <= 1'b0;
			pos_q <= '0;
			trades_q <= '0;
			scan_pos_q <= '0;
			shift_i_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					trades_q <= '0;
					pos_q <= '0;
					full_q <= 1'b0;
					wait_q <= 1'b1;
				end
				ST_HEAD: wait_q <= 1'b1;
				ST_MATCH: begin
					if (wait_q) wait_q <= 1'b0;
					else if (!(out_valid && out_stall)) begin
						wait_q <= 1'b1;
						pos_q <= '0;
						if (is_cross) begin
							trades_q <= trades_q + 1'b1;
						end
					end
				end
				ST_POP: begin
					if (wait_q) wait_q <= 1'b0;
					else begin
						wait_q <= 1'b1;
						if (pos_q + 1'b1 >= opp_n) begin
							count_q[opp_q] <= opp_n - 1'b1;
							pos_q <= '0;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (own_n == CW'(BOOK_DEPTH)) full_q <= 1'b1;
					else if (wait_q) wait_q <= 1'b0;
					else if (pos_q == own_n || !behind) begin
						scan_pos_q <= pos_q;
						shift_i_q <= own_n;
						wait_q <= 1'b1;
					end else begin
						pos_q <= pos_q + 1'b1;
						wait_q <= 1'b1;
					end
				end
				ST_SHIFT: begin
					if (shift_i_q != scan_pos_q) begin
						if (wait_q) wait_q <= 1'b0;
						else begin
							shift_i_q <= shift_i_q - 1'b1;
							wait_q <= 1'b1;
						end
					end
				end
				ST_PUT: count_q[own_q] <= own_n + 1'b1;
				default: ;
			endcase
		end
	end

	logic        r_kind_q, r_rs_q, r_rested_q, r_full_q;
	logic [31:0] r_rid_q, r_iid_q;
	logic [23:0] r_tq_q, r_rl_q, r_il_q;
	logic [19:0] r_tp_q;
	logic [1:0]  r_is_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					sell_q <= side;
					own_q <= zsel | BW'(side);
					opp_q <= zsel | BW'(!side);
					id_q <= order_id;
					limit_q <= limit_price;
					qty_q <= order_quantity;
					rem_q <= order_quantity;
				end
			end
			ST_MATCH: begin
				if (!wait_q && !(out_valid && out_stall) && is_cross) begin
					rem_q <= rem_q - tq;
					r_kind_q <= RK_TRADE;
					r_rid_q <= rid;
					r_iid_q <= id_q;
					r_tq_q <= tq;
					r_tp_q <= rp;
					r_rl_q <= rq - tq;
					r_rs_q <= (rq == tq);
					r_il_q <= rem_q - tq;
					r_is_q <= (rem_q == tq) ? IS_FILLED : IS_PARTIAL;
					r_rested_q <= 1'b0;
					r_full_q <= 1'b0;
				end
			end
			ST_SUM: begin
				if (!(out_valid && out_stall)) begin
					r_kind_q <= RK_SUMMARY;
					r_rid_q <= '0;
					r_iid_q <= id_q;
					r_tq_q <= qty_q - rem_q;
					r_tp_q <= '0;
					r_rl_q <= '0;
					r_rs_q <= 1'b0;
					r_il_q <= rem_q;
					r_is_q <= (rem_q == '0) ? IS_FILLED :
						((rem_q == qty_q) ? IS_NEW : IS_PARTIAL);
					r_rested_q <= (rem_q != '0) && !full_q;
					r_full_q <= (rem_q != '0) && full_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = ovalid_q;
	assign result_kind = r_kind_q;
	assign resting_id = r_rid_q;
	assign incoming_id = r_iid_q;
	assign trade_quantity = r_tq_q;
	assign trade_price = r_tp_q;
	assign resting_left = r_rl_q;
	assign resting_status = r_rs_q;
	assign incoming_left = r_il_q;
	assign incoming_status = r_is_q;
	assign rested = r_rested_q;
	assign book_full = r_full_q;
	assign last = r_kind_q;

	`LOB_ASSERT(a_stall_busy, clk, arst_n, (state_q != ST_IDLE) |-> in_stall)
	`LOB_ASSERT(a_put_room, clk, arst_n, (state_q == ST_PUT) |-> (own_n < CW'(BOOK_DEPTH)))
	`LOB_ASSERT(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> (out_valid && $stable(trade_quantity) && $stable(incoming_id)))
endmodule
